@@ rtl/step_dir_pid_servo_assert.svh @@
// ----------------------------------------------------------------------------
// step/dir servo assertion macros
// shared concurrent assertion forms, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef STEP_DIR_PID_SERVO_ASSERT_SVH
`define STEP_DIR_PID_SERVO_ASSERT_SVH

// same-cycle implication
`define SDPS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sdps_pkg.sv @@
// ----------------------------------------------------------------------------
// step/dir servo package
// item types, register indexes, reset values and saturation helper
// ----------------------------------------------------------------------------
`default_nettype none

package sdps_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_DERIV_GAIN  = 3'd2,
    CFG_DRIVE_LIMIT = 3'd3,
    CFG_WINDOW      = 3'd4,
    CFG_STEP_SIZE   = 3'd5
  } cfg_idx_e;

  localparam logic [15:0] PropGainRst   = 16'd50;
  localparam logic [15:0] IntegGainRst  = 16'd0;
  localparam logic [15:0] DerivGainRst  = 16'd10;
  localparam logic [15:0] DriveLimitRst = 16'd35000;
  localparam logic [15:0] WindowRst     = 16'd5;
  localparam logic [7:0]  StepSizeRst   = 8'd2;

  // encoder wrap windows
  localparam logic [15:0] WrapPrevHi = 16'd65525;
  localparam logic [15:0] WrapCurLo  = 16'd10;
  localparam logic [15:0] WrapPrevLo = 16'd15;
  localparam logic [15:0] WrapCurHi  = 16'd65525;
  localparam logic signed [17:0] CountSpan = 18'sd65536;

  // bridge pin codes, bit 0 is pin A, bit 1 is pin B
  localparam logic [1:0] PinsBrake = 2'b11;
  localparam logic [1:0] PinsFwd   = 2'b10;
  localparam logic [1:0] PinsRev   = 2'b01;

  typedef struct packed {
    logic [15:0] encoder_count;
    logic        step_level;
    logic        dir_level;
    logic        enable_level;
  } sdps_in_t;

  typedef struct packed {
    logic [15:0]        fwd_duty;
    logic [15:0]        rev_duty;
    logic               bridge_a_high;
    logic               bridge_b_high;
    logic               in_position;
    logic               active;
    logic signed [31:0] position_error;
  } sdps_out_t;

  // clamp a 34-bit signed value to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/step_dir_pid_servo.sv @@
// ----------------------------------------------------------------------------
// step/dir PID position servo
// encoder tracking, PID drive and sign-magnitude H-bridge mapping per tick
// ----------------------------------------------------------------------------
// One control tick per input item. The block accepts an item every cycle while
// a stage has room or the result at the output is taken. The error, integrator
// and step tracking close in the first stage, the three gain products sit in
// the second, their sum in the third, and the clamp, duty mapping and held
// bridge state in the output register. Each stage moves on its own as soon as
// the one after it has room, so a result waiting at the output does not block
// intake until all four stages are full. Configuration writes take effect at
// once and are meant for idle periods only.
`default_nettype none

`include "step_dir_pid_servo_assert.svh"

module step_dir_pid_servo
  import sdps_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sdps_in_t            in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output sdps_out_t                out_item_o
);

  typedef struct packed {
    logic               run;
    logic               dis;
    logic               active;
    logic               inpos;
    logic signed [31:0] err;
    logic signed [31:0] integ;
    logic signed [32:0] derr;
  } st1_t;

  typedef struct packed {
    logic               run;
    logic               dis;
    logic               active;
    logic               inpos;
    logic signed [31:0] err;
    logic signed [48:0] prod_p;
    logic signed [48:0] prod_i;
    logic signed [49:0] prod_d;
  } st2_t;

  typedef struct packed {
    logic               run;
    logic               dis;
    logic               active;
    logic               inpos;
    logic signed [31:0] err;
    logic signed [51:0] sum;
  } st3_t;

  // configuration
  logic [15:0] prop_gain_q, integ_gain_q, deriv_gain_q, drive_limit_q, window_q;
  logic [7:0]  step_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= PropGainRst;
      integ_gain_q  <= IntegGainRst;
      deriv_gain_q  <= DerivGainRst;
      drive_limit_q <= DriveLimitRst;
      window_q      <= WindowRst;
      step_size_q   <= StepSizeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PROP_GAIN:   prop_gain_q   <= cfg_data_i;
        CFG_INTEG_GAIN:  integ_gain_q  <= cfg_data_i;
        CFG_DERIV_GAIN:  deriv_gain_q  <= cfg_data_i;
        CFG_DRIVE_LIMIT: drive_limit_q <= cfg_data_i;
        CFG_WINDOW:      window_q      <= cfg_data_i;
        CFG_STEP_SIZE:   step_size_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic in_acc;

  assign rdy4       = !v4_q || out_ready_i;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign in_acc     = in_valid_i && rdy1;

  // stage 1: loop state
  logic [15:0]        prev_count_q, prev_count_d;
  logic signed [31:0] track_error_q, track_error_d;
  logic signed [31:0] integ_sum_q, integ_sum_d;
  logic signed [31:0] last_err_q, last_err_d;
  logic               step_armed_q, step_armed_d;
  logic               enabled_q, enabled_d;

  logic               run;
  logic               wrap_up, wrap_dn;
  logic signed [17:0] diff, delta;
  logic signed [31:0] te_sub;
  logic signed [32:0] err33, win33;
  logic signed [33:0] step34;
  st1_t               s1_d, s1_q;

  always_comb begin
    run     = enabled_q || !in_item_i.enable_level;
    diff    = $signed({2'b00, in_item_i.encoder_count}) - $signed({2'b00, prev_count_q});
    wrap_up = (prev_count_q > WrapPrevHi) && (in_item_i.encoder_count < WrapCurLo);
    wrap_dn = (prev_count_q < WrapPrevLo) && (in_item_i.encoder_count > WrapCurHi);
    if (wrap_up) begin
      delta = diff + CountSpan;
    end else if (wrap_dn) begin
      delta = diff - CountSpan;
    end else begin
      delta = diff;
    end
    te_sub = sat32({{2{track_error_q[31]}}, track_error_q} - {{16{delta[17]}}, delta});
    err33  = {te_sub[31], te_sub};
    win33  = $signed({17'b0, window_q});
    step34 = $signed({26'b0, step_size_q});

    prev_count_d  = prev_count_q;
    track_error_d = track_error_q;
    integ_sum_d   = integ_sum_q;
    last_err_d    = last_err_q;
    step_armed_d  = step_armed_q;
    enabled_d     = run && !in_item_i.enable_level;

    s1_d.run    = run;
    s1_d.dis    = run && in_item_i.enable_level;
    s1_d.active = run && !in_item_i.enable_level;
    s1_d.inpos  = (err33 < win33) && (err33 > -win33);
    s1_d.err    = run ? te_sub : track_error_q;
    s1_d.integ  = sat32({{2{integ_sum_q[31]}}, integ_sum_q} + {{2{te_sub[31]}}, te_sub});
    s1_d.derr   = err33 - {last_err_q[31], last_err_q};

    if (run) begin
      prev_count_d  = in_item_i.encoder_count;
      track_error_d = te_sub;
      integ_sum_d   = s1_d.integ;
      last_err_d    = te_sub;
      if (in_item_i.step_level) begin
        step_armed_d = 1'b0;
      end else if (!step_armed_q) begin
        // falling step edge seen, moves the next tick's error
        step_armed_d = 1'b1;
        if (in_item_i.dir_level) begin
          track_error_d = sat32({{2{te_sub[31]}}, te_sub} + step34);
        end else begin
          track_error_d = sat32({{2{te_sub[31]}}, te_sub} - step34);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_count_q  <= '0;
      track_error_q <= '0;
      integ_sum_q   <= '0;
      last_err_q    <= '0;
      step_armed_q  <= 1'b0;
      enabled_q     <= 1'b0;
    end else if (in_acc) begin
      prev_count_q  <= prev_count_d;
      track_error_q <= track_error_d;
      integ_sum_q   <= integ_sum_d;
      last_err_q    <= last_err_d;
      step_armed_q  <= step_armed_d;
      enabled_q     <= enabled_d;
    end
  end

  // stage 2: gain products
  st2_t s2_d, s2_q;

  always_comb begin
    s2_d.run    = s1_q.run;
    s2_d.dis    = s1_q.dis;
    s2_d.active = s1_q.active;
    s2_d.inpos  = s1_q.inpos;
    s2_d.err    = s1_q.err;
    s2_d.prod_p = $signed({1'b0, prop_gain_q}) * s1_q.err;
    s2_d.prod_i = $signed({1'b0, integ_gain_q}) * s1_q.integ;
    s2_d.prod_d = $signed({1'b0, deriv_gain_q}) * s1_q.derr;
  end

  // stage 3: PID sum
  st3_t s3_d, s3_q;

  always_comb begin
    s3_d.run    = s2_q.run;
    s3_d.dis    = s2_q.dis;
    s3_d.active = s2_q.active;
    s3_d.inpos  = s2_q.inpos;
    s3_d.err    = s2_q.err;
    s3_d.sum    = {{3{s2_q.prod_p[48]}}, s2_q.prod_p}
                + {{3{s2_q.prod_i[48]}}, s2_q.prod_i}
                + {{2{s2_q.prod_d[49]}}, s2_q.prod_d};
  end

  // stage 4: clamp, bridge mapping and held outputs
  logic signed [51:0] lim52, nsum;
  logic               lim_nz, drv_pos, drv_neg;
  logic [15:0]        mag_pos, mag_neg;
  sdps_out_t          out_d, out_q;

  always_comb begin
    lim52   = $signed({36'b0, drive_limit_q});
    nsum    = -s3_q.sum;
    lim_nz  = (drive_limit_q != '0);
    drv_pos = lim_nz && !s3_q.sum[51] && (s3_q.sum != '0);
    drv_neg = lim_nz && s3_q.sum[51];
    mag_pos = (s3_q.sum > lim52) ? drive_limit_q : s3_q.sum[15:0];
    mag_neg = (nsum > lim52) ? drive_limit_q : nsum[15:0];

    out_d                = out_q;
    out_d.active         = s3_q.active;
    out_d.position_error = s3_q.err;
    if (s3_q.run) begin
      out_d.in_position = s3_q.inpos;
      if (s3_q.dis) begin
        out_d.fwd_duty = '0;
        out_d.rev_duty = '0;
        {out_d.bridge_b_high, out_d.bridge_a_high} = PinsBrake;
      end else if (drv_pos) begin
        out_d.fwd_duty = mag_pos;
        out_d.rev_duty = '0;
        {out_d.bridge_b_high, out_d.bridge_a_high} = PinsFwd;
      end else if (drv_neg) begin
        out_d.fwd_duty = '0;
        out_d.rev_duty = mag_neg;
        {out_d.bridge_b_high, out_d.bridge_a_high} = PinsRev;
      end else if (s3_q.err == '0) begin
        out_d.fwd_duty = '0;
        out_d.rev_duty = '0;
        {out_d.bridge_b_high, out_d.bridge_a_high} = PinsBrake;
      end
      // zero drive with nonzero error keeps the held bridge state
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (v1_q && rdy2) begin
      s2_q <= s2_d;
    end
    if (v2_q && rdy3) begin
      s3_q <= s3_d;
    end
  end

  // output register doubles as the held bridge state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q.fwd_duty       <= '0;
      out_q.rev_duty       <= '0;
      out_q.bridge_a_high  <= PinsBrake[0];
      out_q.bridge_b_high  <= PinsBrake[1];
      out_q.in_position    <= 1'b0;
      out_q.active         <= 1'b0;
      out_q.position_error <= '0;
    end else if (v3_q && rdy4) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_item_o  = out_q;

  `SDPS_ASSERT_IMPL(a_duty_excl, out_valid_o, (out_item_o.fwd_duty == '0) || (out_item_o.rev_duty == '0), "both duties nonzero")
  `SDPS_ASSERT_IMPL(a_fwd_pins, out_valid_o && (out_item_o.fwd_duty != '0), !out_item_o.bridge_a_high && out_item_o.bridge_b_high, "forward duty with wrong pins")
  `SDPS_ASSERT_IMPL(a_rev_pins, out_valid_o && (out_item_o.rev_duty != '0), out_item_o.bridge_a_high && !out_item_o.bridge_b_high, "reverse duty with wrong pins")
  `SDPS_ASSERT_NEXT(a_disable, in_acc && in_item_i.enable_level, !enabled_q, "loop still enabled after enable released")

endmodule

`default_nettype wire

@@ test/servo_checker.sv @@
// ----------------------------------------------------------------------------
// step/dir servo checker
// tracks the servo state on its own, predicts every control tick and compares
// each result item field by field against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module servo_checker
  import sdps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  cfg_idx_e            cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  sdps_in_t            in_item_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  sdps_out_t           out_item_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  logic [15:0]        kp, ki, kd, drive_lim, win;
  logic [7:0]         step_amt;

  logic [15:0]        last_count;
  logic signed [31:0] trk_err, err_sum, prev_err;
  logic               armed, loop_on, inpos;
  logic [15:0]        duty_fwd, duty_rev;
  logic [1:0]         pins;

  sdps_out_t servo_q[$];
  int        fail_count = 0;

  assign fail_count_o = fail_count;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // one control tick: advances the servo state and returns the result item
  function automatic sdps_out_t servo_tick(input sdps_in_t t);
    sdps_out_t          res;
    longint             cur, prev, delta, drive, lim, w;
    logic signed [31:0] err_now;
    logic               ran;
    cur     = longint'(t.encoder_count);
    err_now = trk_err;
    ran     = 1'b0;
    if (!loop_on && !t.enable_level) loop_on = 1'b1;
    if (loop_on) begin
      ran        = 1'b1;
      prev       = longint'(last_count);
      last_count = t.encoder_count;
      // wrap is only recognized inside the two narrow windows
      if (prev > 65525 && cur < 10) begin
        delta = cur + 65536 - prev;
      end else if (prev < 15 && cur > 65525) begin
        delta = cur - prev - 65536;
      end else begin
        delta = cur - prev;
      end
      trk_err = clamp32(longint'(trk_err) - delta);
      err_now = trk_err;
      err_sum = clamp32(longint'(err_sum) + longint'(err_now));
      drive = longint'(kp) * longint'(err_now)
            + longint'(ki) * longint'(err_sum)
            + longint'(kd) * (longint'(err_now) - longint'(prev_err));
      lim = longint'(drive_lim);
      if (drive > lim) begin
        drive = lim;
      end else if (drive < -lim) begin
        drive = -lim;
      end
      if (drive > 0) begin
        duty_fwd = drive[15:0];
        duty_rev = '0;
        pins     = PinsFwd;
      end else if (drive < 0) begin
        duty_fwd = '0;
        duty_rev = 16'(-drive);
        pins     = PinsRev;
      end else if (err_now == 0) begin
        duty_fwd = '0;
        duty_rev = '0;
        pins     = PinsBrake;
      end
      // zero drive with a nonzero error keeps the bridge as it was
      prev_err = err_now;
      w        = longint'(win);
      inpos    = (longint'(err_now) < w) && (longint'(err_now) > -w);
      if (t.step_level) begin
        armed = 1'b0;
      end else if (!armed) begin
        armed = 1'b1;
        if (t.dir_level) begin
          trk_err = clamp32(longint'(trk_err) + longint'(step_amt));
        end else begin
          trk_err = clamp32(longint'(trk_err) - longint'(step_amt));
        end
      end
      if (t.enable_level) begin
        loop_on  = 1'b0;
        duty_fwd = '0;
        duty_rev = '0;
        pins     = PinsBrake;
      end
    end
    res.fwd_duty       = duty_fwd;
    res.rev_duty       = duty_rev;
    res.bridge_a_high  = pins[0];
    res.bridge_b_high  = pins[1];
    res.in_position    = inpos;
    res.active         = ran && loop_on;
    res.position_error = err_now;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sdps_out_t want;
    if (!rst_ni) begin
      kp         = PropGainRst;
      ki         = IntegGainRst;
      kd         = DerivGainRst;
      drive_lim  = DriveLimitRst;
      win        = WindowRst;
      step_amt   = StepSizeRst;
      last_count = '0;
      trk_err    = '0;
      err_sum    = '0;
      prev_err   = '0;
      armed      = 1'b0;
      loop_on    = 1'b0;
      inpos      = 1'b0;
      duty_fwd   = '0;
      duty_rev   = '0;
      pins       = PinsBrake;
      servo_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PROP_GAIN:   kp = cfg_data_i;
          CFG_INTEG_GAIN:  ki = cfg_data_i;
          CFG_DERIV_GAIN:  kd = cfg_data_i;
          CFG_DRIVE_LIMIT: drive_lim = cfg_data_i;
          CFG_WINDOW:      win = cfg_data_i;
          CFG_STEP_SIZE:   step_amt = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (servo_q.size() == 0) begin
          report_mismatch("result item with no tick waiting");
        end else begin
          want = servo_q.pop_front();
          check_field("fwd_duty", out_item_i.fwd_duty, want.fwd_duty);
          check_field("rev_duty", out_item_i.rev_duty, want.rev_duty);
          check_field("bridge_a_high", out_item_i.bridge_a_high, want.bridge_a_high);
          check_field("bridge_b_high", out_item_i.bridge_b_high, want.bridge_b_high);
          check_field("in_position", out_item_i.in_position, want.in_position);
          check_field("active", out_item_i.active, want.active);
          check_field("position_error", out_item_i.position_error, want.position_error);
        end
      end
      if (in_valid_i && in_ready_i) begin
        servo_q.push_back(servo_tick(in_item_i));
      end
      pending_o <= servo_q.size();
    end
  end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// step/dir servo testbench
// directed ticks through enable, step edges and encoder wrap, then random
// ticks under several gain settings and a runaway of the tracking error
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sdps_pkg::*;

  localparam int CycleLimit = 2_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_e            cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  sdps_in_t            in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  sdps_out_t           out_item_o;

  int          fail_count;
  int          results_pending;
  int          cycle_count = 0;
  int          off_left = 0;
  bit          calm = 1'b0;
  logic [15:0] shaft = '0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  step_dir_pid_servo u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .in_item_i,
    .out_valid_o,
    .out_ready_i,
    .out_item_o
  );

  servo_checker u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_i   (in_ready_o),
    .in_item_i,
    .out_valid_i  (out_valid_o),
    .out_ready_i,
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (results_pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stall before each item
  initial begin
    int gap;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 17);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_tick(input logic [15:0] enc, input logic stp, input logic dir,
                           input logic off);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{encoder_count: enc, step_level: stp, dir_level: dir,
                    enable_level: off};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_enc(input logic [15:0] enc);
    shaft = enc;
    send_tick(enc, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_servo(input logic [15:0] p, input logic [15:0] i,
                            input logic [15:0] d, input logic [15:0] lim,
                            input logic [15:0] win, input logic [7:0] stp);
    drain();
    write_reg(CFG_PROP_GAIN, p);
    write_reg(CFG_INTEG_GAIN, i);
    write_reg(CFG_DERIV_GAIN, d);
    write_reg(CFG_DRIVE_LIMIT, lim);
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_STEP_SIZE, {8'd0, stp});
    cfg_we_i <= 1'b0;
    calm = ($urandom_range(0, 3) == 0);
  endtask

  function automatic logic [15:0] pick_gain();
    return ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 200)) : 16'($urandom());
  endfunction

  // mostly smooth shaft motion, some wrap-window jumps and wild samples
  task automatic random_ticks(input int count);
    int   pick;
    logic off;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        shaft = shaft + 16'($urandom_range(0, 40)) - 16'd20;
      end else if (pick < 75) begin
        shaft = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(65515, 65535))
                                             : 16'($urandom_range(0, 20));
      end else if (pick < 85) begin
        shaft = 16'($urandom());
      end
      if (off_left == 0 && $urandom_range(0, 99) < 4) off_left = $urandom_range(1, 4);
      off = (off_left != 0);
      if (off) off_left--;
      send_tick(shaft, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), off);
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= CFG_PROP_GAIN;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    in_item_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // disabled tick sees nothing, then enable and step edges both ways
    send_tick(16'd1234, 1'b0, 1'b1, 1'b1);
    send_tick(16'd0, 1'b1, 1'b1, 1'b0);
    send_tick(16'd0, 1'b0, 1'b1, 1'b0);
    send_tick(16'd0, 1'b0, 1'b1, 1'b0);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0);
    send_tick(16'd0, 1'b0, 1'b0, 1'b0);
    // wrap windows and their edges
    send_tick(16'd65530, 1'b1, 1'b0, 1'b0);
    send_tick(16'd5, 1'b1, 1'b0, 1'b0);
    send_tick(16'd65535, 1'b1, 1'b0, 1'b0);
    send_tick(16'd10, 1'b1, 1'b0, 1'b0);
    send_tick(16'd14, 1'b1, 1'b0, 1'b0);
    send_tick(16'd65526, 1'b1, 1'b0, 1'b0);
    send_tick(16'd9, 1'b1, 1'b0, 1'b0);
    send_tick(16'd15, 1'b1, 1'b0, 1'b0);
    send_tick(16'd65535, 1'b1, 1'b0, 1'b0);
    send_tick(16'd65525, 1'b1, 1'b0, 1'b0);
    send_tick(16'd0, 1'b1, 1'b0, 1'b0);
    // disable while running, stay off, come back with a step edge
    send_tick(16'd0, 1'b1, 1'b1, 1'b1);
    send_tick(16'd0, 1'b0, 1'b1, 1'b1);
    send_tick(16'd0, 1'b0, 1'b1, 1'b0);

    load_servo(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    random_ticks(40);
    // no gain at all: bridge brakes at zero error and holds otherwise
    load_servo(16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 8'd0);
    random_ticks(30);
    // drive limit of zero
    load_servo(16'd1, 16'd0, 16'd0, 16'd0, 16'd5, 8'd1);
    random_ticks(30);
    repeat (5) begin
      load_servo(pick_gain(), pick_gain(), pick_gain(), 16'($urandom_range(1, 65535)),
                 pick_gain(), 8'($urandom_range(0, 255)));
      random_ticks(30);
    end

    // runaway: push the error far negative, then well over into positive
    load_servo(pick_gain(), pick_gain(), pick_gain(), 16'hFFFF, pick_gain(),
               8'($urandom_range(0, 255)));
    calm = 1'b1;
    repeat (20) begin
      send_enc(16'($urandom_range(15, 30)));
      send_enc(16'($urandom_range(65526, 65535)));
      send_enc(16'($urandom_range(0, 9)));
    end
    repeat (30) begin
      send_enc(16'($urandom_range(10, 14)));
      send_enc(16'($urandom_range(65526, 65535)));
    end
    send_tick(16'd0, 1'b1, 1'b1, 1'b1);
    calm = 1'b0;

    drain();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
